@@ hw/rtl/fcr_pkg.sv @@
// ----------------------------------------------------------------------------
// fcr_pkg
// Shared types, codes and helper functions of the framed command receiver.
// ----------------------------------------------------------------------------
package fcr_pkg;

  // Default for the largest accepted payload length.
  localparam int unsigned MAX_PAYLOAD_DEF = 1024;

  // Frame constants.
  localparam logic [7:0]  SYNC_BYTE = 8'h7F;
  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
  localparam logic [31:0] WORD_FILL = 32'hFFFFFFFF;

  // Configuration register reset values.
  localparam logic [31:0] REGION_START_RST = 32'h08010000;
  localparam logic [31:0] REGION_END_RST   = 32'h08080000;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_END   = 1'b1;

  // Command codes.
  localparam logic [7:0] OP_PING   = 8'h01;
  localparam logic [7:0] OP_ERASE  = 8'h02;
  localparam logic [7:0] OP_WRITE  = 8'h03;
  localparam logic [7:0] OP_VERIFY = 8'h04;
  localparam logic [7:0] OP_JUMP   = 8'h05;

  // Result kinds.
  localparam logic KIND_WORD    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Verdict status codes.
  localparam logic [2:0] ST_ACK        = 3'd0;
  localparam logic [2:0] ST_TOO_LONG   = 3'd1;
  localparam logic [2:0] ST_CRC_BAD    = 3'd2;
  localparam logic [2:0] ST_WR_SHORT   = 3'd3;
  localparam logic [2:0] ST_RANGE      = 3'd4;
  localparam logic [2:0] ST_VLEN_BAD   = 3'd5;
  localparam logic [2:0] ST_UNKNOWN    = 3'd6;

  // Verdict action codes.
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_ERASE  = 3'd1;
  localparam logic [2:0] ACT_COMMIT = 3'd2;
  localparam logic [2:0] ACT_VERIFY = 3'd3;
  localparam logic [2:0] ACT_JUMP   = 3'd4;

  // One result word.
  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [2:0]  action;
    logic [31:0] address;
    logic [31:0] word;
    logic [31:0] length;
  } result_t;

  // Reflected CRC32 update over one byte, one bit per step.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  // Region check with a 33-bit end sum so the range never wraps.
  function automatic logic in_region(input logic [31:0] start, input logic [31:0] count,
                                     input logic [31:0] rs, input logic [31:0] re);
    logic [32:0] top;
    top = {1'b0, start} + {1'b0, count};
    return (start >= rs) && (top <= {1'b0, re});
  endfunction

endpackage

@@ hw/rtl/fcr_parser.sv @@
// ----------------------------------------------------------------------------
// fcr_parser
// Frame state machine: sync hunt, header, payload and CRC, with the result
// of each accepted byte presented combinationally.
// ----------------------------------------------------------------------------
module fcr_parser #(
  parameter int unsigned MAX_PAYLOAD = fcr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  input  logic [31:0]      region_start,
  input  logic [31:0]      region_end,
  output logic             res_valid,
  output fcr_pkg::result_t res
);

  localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_CMD,
    PH_LENHI,
    PH_LENLO,
    PH_PAYLOAD,
    PH_CRC
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [15:0]      flen_r, flen_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic [31:0]      rcrc_r, rcrc_nxt;
  logic [31:0]      addr_r, addr_nxt;
  logic [31:0]      vlen_r, vlen_nxt;
  logic [31:0]      wbuf_r, wbuf_nxt;
  logic             range_ok_r, range_ok_nxt;

  logic [CNT_W:0]   idx_inc;
  logic             last_byte;
  logic [CNT_W-1:0] data_idx;
  logic [1:0]       lane;
  logic [31:0]      crc_upd;

  assign crc_upd   = fcr_pkg::crc32_byte(crc_r, rx_byte);
  assign idx_inc   = {1'b0, cnt_r} + {{CNT_W{1'b0}}, 1'b1};
  assign last_byte = {{(16 - CNT_W){1'b0}}, idx_inc} >= {1'b0, flen_r};
  assign data_idx  = cnt_r - CNT_W'(4);
  assign lane      = data_idx[1:0];

  // Verdict at the end of a frame, checks in order of precedence.
  function automatic fcr_pkg::result_t verdict(input logic [31:0] rcrc);
    fcr_pkg::result_t v;
    v        = '0;
    v.kind   = fcr_pkg::KIND_VERDICT;
    v.status = fcr_pkg::ST_ACK;
    v.action = fcr_pkg::ACT_NONE;
    if (~crc_r != rcrc) begin
      v.status = fcr_pkg::ST_CRC_BAD;
    end else begin
      case (cmd_r)
        fcr_pkg::OP_PING: begin
          v.status = fcr_pkg::ST_ACK;
        end
        fcr_pkg::OP_ERASE: begin
          v.action = fcr_pkg::ACT_ERASE;
        end
        fcr_pkg::OP_WRITE: begin
          if (flen_r < 16'd5) begin
            v.status = fcr_pkg::ST_WR_SHORT;
          end else if (!range_ok_r) begin
            v.status = fcr_pkg::ST_RANGE;
          end else begin
            v.action  = fcr_pkg::ACT_COMMIT;
            v.address = addr_r;
            v.length  = {16'd0, flen_r} - 32'd4;
          end
        end
        fcr_pkg::OP_VERIFY: begin
          if (flen_r != 16'd8) begin
            v.status = fcr_pkg::ST_VLEN_BAD;
          end else if (!fcr_pkg::in_region(addr_r, vlen_r, region_start, region_end)) begin
            v.status = fcr_pkg::ST_RANGE;
          end else begin
            v.action  = fcr_pkg::ACT_VERIFY;
            v.address = addr_r;
            v.length  = vlen_r;
          end
        end
        fcr_pkg::OP_JUMP: begin
          v.action = fcr_pkg::ACT_JUMP;
        end
        default: begin
          v.status = fcr_pkg::ST_UNKNOWN;
        end
      endcase
    end
    return v;
  endfunction

  // Next state and result for the byte being accepted.
  always_comb begin
    phase_nxt    = phase_r;
    cmd_nxt      = cmd_r;
    flen_nxt     = flen_r;
    cnt_nxt      = cnt_r;
    crc_nxt      = crc_r;
    rcrc_nxt     = rcrc_r;
    addr_nxt     = addr_r;
    vlen_nxt     = vlen_r;
    wbuf_nxt     = wbuf_r;
    range_ok_nxt = range_ok_r;
    res_valid    = 1'b0;
    res          = '0;
    if (step) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (rx_byte == fcr_pkg::SYNC_BYTE) begin
            crc_nxt      = fcr_pkg::CRC_INIT;
            rcrc_nxt     = '0;
            addr_nxt     = '0;
            vlen_nxt     = '0;
            wbuf_nxt     = fcr_pkg::WORD_FILL;
            range_ok_nxt = 1'b0;
            cnt_nxt      = '0;
            phase_nxt    = PH_CMD;
          end
        end
        PH_CMD: begin
          cmd_nxt   = rx_byte;
          crc_nxt   = crc_upd;
          phase_nxt = PH_LENHI;
        end
        PH_LENHI: begin
          flen_nxt  = {rx_byte, 8'd0};
          crc_nxt   = crc_upd;
          phase_nxt = PH_LENLO;
        end
        PH_LENLO: begin
          flen_nxt = {flen_r[15:8], rx_byte};
          crc_nxt  = crc_upd;
          cnt_nxt  = '0;
          if (flen_nxt > 16'(MAX_PAYLOAD)) begin
            phase_nxt  = PH_HUNT;
            res_valid  = 1'b1;
            res.kind   = fcr_pkg::KIND_VERDICT;
            res.status = fcr_pkg::ST_TOO_LONG;
            res.action = fcr_pkg::ACT_NONE;
          end else if (flen_nxt == 16'd0) begin
            phase_nxt = PH_CRC;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          crc_nxt = crc_upd;
          cnt_nxt = idx_inc[CNT_W-1:0];
          if (last_byte) begin
            phase_nxt = PH_CRC;
            cnt_nxt   = '0;
          end
          if (cnt_r < CNT_W'(4)) begin
            // Address bytes, big-endian; WRITE range is checked on the last one.
            addr_nxt = {addr_r[23:0], rx_byte};
            if (cnt_r == CNT_W'(3) && cmd_r == fcr_pkg::OP_WRITE && flen_r >= 16'd5) begin
              range_ok_nxt = fcr_pkg::in_region(addr_nxt, {16'd0, flen_r} - 32'd4,
                                                region_start, region_end);
            end
          end else if (cmd_r == fcr_pkg::OP_VERIFY) begin
            if (cnt_r < CNT_W'(8)) begin
              vlen_nxt = {vlen_r[23:0], rx_byte};
            end
          end else if (cmd_r == fcr_pkg::OP_WRITE && range_ok_r) begin
            // Pack data bytes little-endian and issue a word when full or at the end.
            wbuf_nxt = wbuf_r;
            wbuf_nxt[lane*8 +: 8] = rx_byte;
            if (lane == 2'd3 || last_byte) begin
              res_valid   = 1'b1;
              res.kind    = fcr_pkg::KIND_WORD;
              res.status  = fcr_pkg::ST_ACK;
              res.action  = fcr_pkg::ACT_NONE;
              res.address = addr_r + 32'({data_idx[CNT_W-1:2], 2'b00});
              res.word    = wbuf_nxt;
              res.length  = 32'({1'b0, lane} + 3'd1);
              wbuf_nxt    = fcr_pkg::WORD_FILL;
            end
          end
        end
        PH_CRC: begin
          rcrc_nxt = {rcrc_r[23:0], rx_byte};
          cnt_nxt  = idx_inc[CNT_W-1:0];
          if (cnt_r == CNT_W'(3)) begin
            phase_nxt = PH_HUNT;
            cnt_nxt   = '0;
            res_valid = 1'b1;
            res       = verdict(rcrc_nxt);
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      cmd_r      <= '0;
      flen_r     <= '0;
      cnt_r      <= '0;
      crc_r      <= fcr_pkg::CRC_INIT;
      rcrc_r     <= '0;
      addr_r     <= '0;
      vlen_r     <= '0;
      wbuf_r     <= fcr_pkg::WORD_FILL;
      range_ok_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      cmd_r      <= cmd_nxt;
      flen_r     <= flen_nxt;
      cnt_r      <= cnt_nxt;
      crc_r      <= crc_nxt;
      rcrc_r     <= rcrc_nxt;
      addr_r     <= addr_nxt;
      vlen_r     <= vlen_nxt;
      wbuf_r     <= wbuf_nxt;
      range_ok_r <= range_ok_nxt;
    end
  end

endmodule

@@ hw/rtl/framed_command_receiver_crc32.sv @@
// Each result is registered in the output register, or in the skid entry if it is stalled.
// Throughput: one byte per cycle while in_ready is high; state and CRC update per byte.
// A two-entry output buffer keeps bytes flowing while a word waits; in_ready drops
// only when both entries hold results.
// Reset (synchronous, rst_n low): sync hunt, output buffer empty, regions at defaults.
// ----------------------------------------------------------------------------
// framed_command_receiver_crc32
// Receives framed commands byte by byte, checks CRC32 and ranges, and issues
// program words and frame verdicts.
// ----------------------------------------------------------------------------
module framed_command_receiver_crc32 #(
  parameter int unsigned MAX_PAYLOAD = fcr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_rx_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_kind,
  output logic [2:0]                   out_status,
  output logic [2:0]                   out_action,
  output logic [31:0]                  out_address,
  output logic [31:0]                  out_word,
  output logic [31:0]                  out_length,
  input  logic                         cfg_we,
  input  logic [fcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                  cfg_data
);

  logic [31:0]      region_start_r;
  logic [31:0]      region_end_r;
  logic             step;
  logic             res_valid;
  fcr_pkg::result_t res;
  fcr_pkg::result_t out_r;
  fcr_pkg::result_t skid_r;
  logic             out_valid_r;
  logic             skid_valid_r;
  logic             pop;
  logic             push;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_start_r <= fcr_pkg::REGION_START_RST;
      region_end_r   <= fcr_pkg::REGION_END_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fcr_pkg::REG_REGION_START: region_start_r <= cfg_data;
        fcr_pkg::REG_REGION_END:   region_end_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame parser.
  fcr_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .rx_byte      (in_rx_byte),
    .region_start (region_start_r),
    .region_end   (region_end_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  // Handshake: take a byte whenever the skid entry is free.
  assign in_ready = !skid_valid_r;
  assign step     = in_valid && in_ready;
  assign pop      = out_valid_r && out_ready;
  assign push     = step && res_valid;

  // Two-entry output buffer: output register plus skid entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (pop) begin
          out_r        <= skid_r;
          skid_valid_r <= 1'b0;
        end
      end else if (!out_valid_r || pop) begin
        out_valid_r <= push;
        if (push) begin
          out_r <= res;
        end
      end else if (push) begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_r.kind;
  assign out_status  = out_r.status;
  assign out_action  = out_r.action;
  assign out_address = out_r.address;
  assign out_word    = out_r.word;
  assign out_length  = out_r.length;

endmodule

@@ tb/sv/tb_framed_command_receiver_crc32.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_framed_command_receiver_crc32
// Streams framed commands into the receiver one byte per word. This covers
// sync noise, every command, bad CRCs, length limits, range edges and
// truncated frames. A byte-level model of the frame parser predicts every
// program word and verdict, and each one is checked field by field.
// ----------------------------------------------------------------------------
module tb_framed_command_receiver_crc32;

  localparam int unsigned MAX_LEN      = fcr_pkg::MAX_PAYLOAD_DEF;
  localparam int unsigned RANDOM_BYTES = 630;
  localparam int unsigned SETTLE       = 4;
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned LONG_HOLD    = 400;

  typedef enum logic [2:0] {
    RX_HUNT, RX_CMD, RX_LEN_HI, RX_LEN_LO, RX_PAYLOAD, RX_CRC
  } rx_phase_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [7:0]                    in_rx_byte = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          out_kind;
  logic [2:0]                    out_status;
  logic [2:0]                    out_action;
  logic [31:0]                   out_address;
  logic [31:0]                   out_word;
  logic [31:0]                   out_length;
  logic                          cfg_we = 1'b0;
  logic [fcr_pkg::CFG_IDX_W-1:0] cfg_index = fcr_pkg::REG_REGION_START;
  logic [31:0]                   cfg_data = '0;

  // Parser model state, mirrors the block after reset.
  rx_phase_t   m_phase = RX_HUNT;
  logic [7:0]  m_cmd = '0;
  logic [15:0] m_len = '0;
  int unsigned m_count = 0;
  logic [31:0] m_crc = fcr_pkg::CRC_INIT;
  logic [31:0] m_rx_crc = '0;
  logic [31:0] m_addr = '0;
  logic [31:0] m_vlen = '0;
  logic [31:0] m_wbuf = fcr_pkg::WORD_FILL;
  logic        m_range_ok = 1'b0;
  logic [31:0] m_region_start = fcr_pkg::REGION_START_RST;
  logic [31:0] m_region_end = fcr_pkg::REGION_END_RST;

  fcr_pkg::result_t pending_results[$];

  // Run control and bookkeeping.
  bit          no_idle = 1'b0;
  int unsigned sink_hold_cycles = 0;
  int unsigned cycle_count = 0;
  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned words_checked = 0;
  int unsigned verdicts_checked = 0;
  int unsigned region_settings = 1;
  int unsigned status_seen[7];

  framed_command_receiver_crc32 #(
    .MAX_PAYLOAD(MAX_LEN)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_rx_byte  (in_rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .out_status  (out_status),
    .out_action  (out_action),
    .out_address (out_address),
    .out_word    (out_word),
    .out_length  (out_length),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reflected CRC32, folding in one data bit per shift.
  function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ data[k]) c = (c >> 1) ^ fcr_pkg::CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  // True when [start, start + count) lies inside the region, summed without wrap.
  function automatic bit region_fits(input logic [31:0] start, input logic [31:0] count);
    longint unsigned top;
    top = longint'(start) + longint'(count);
    return (start >= m_region_start) && (top <= longint'(m_region_end));
  endfunction

  // Verdict at the last CRC byte: CRC first, then per-command checks.
  function automatic fcr_pkg::result_t frame_verdict();
    fcr_pkg::result_t r;
    r = '0;
    r.kind = fcr_pkg::KIND_VERDICT;
    r.status = fcr_pkg::ST_ACK;
    r.action = fcr_pkg::ACT_NONE;
    if (~m_crc != m_rx_crc) begin
      r.status = fcr_pkg::ST_CRC_BAD;
    end else begin
      case (m_cmd)
        fcr_pkg::OP_PING: ;
        fcr_pkg::OP_ERASE: r.action = fcr_pkg::ACT_ERASE;
        fcr_pkg::OP_WRITE: begin
          if (m_len < 16'd5) r.status = fcr_pkg::ST_WR_SHORT;
          else if (!m_range_ok) r.status = fcr_pkg::ST_RANGE;
          else begin
            r.action = fcr_pkg::ACT_COMMIT;
            r.address = m_addr;
            r.length = {16'd0, m_len} - 32'd4;
          end
        end
        fcr_pkg::OP_VERIFY: begin
          if (m_len != 16'd8) r.status = fcr_pkg::ST_VLEN_BAD;
          else if (!region_fits(m_addr, m_vlen)) r.status = fcr_pkg::ST_RANGE;
          else begin
            r.action = fcr_pkg::ACT_VERIFY;
            r.address = m_addr;
            r.length = m_vlen;
          end
        end
        fcr_pkg::OP_JUMP: r.action = fcr_pkg::ACT_JUMP;
        default: r.status = fcr_pkg::ST_UNKNOWN;
      endcase
    end
    return r;
  endfunction

  // Advance the parser model by one accepted byte and queue what it produces.
  task automatic track_rx_byte(input logic [7:0] b);
    fcr_pkg::result_t r;
    int unsigned      idx;
    logic [1:0]       lane;
    logic [31:0]      d;
    case (m_phase)
      RX_HUNT: begin
        if (b == fcr_pkg::SYNC_BYTE) begin
          m_crc = fcr_pkg::CRC_INIT;
          m_rx_crc = '0;
          m_addr = '0;
          m_vlen = '0;
          m_wbuf = fcr_pkg::WORD_FILL;
          m_range_ok = 1'b0;
          m_count = 0;
          m_phase = RX_CMD;
        end
      end
      RX_CMD: begin
        m_cmd = b;
        m_crc = crc32_update(m_crc, b);
        m_phase = RX_LEN_HI;
      end
      RX_LEN_HI: begin
        m_len = {b, 8'h00};
        m_crc = crc32_update(m_crc, b);
        m_phase = RX_LEN_LO;
      end
      RX_LEN_LO: begin
        m_len[7:0] = b;
        m_crc = crc32_update(m_crc, b);
        m_count = 0;
        if (m_len > MAX_LEN) begin
          r = '0;
          r.kind = fcr_pkg::KIND_VERDICT;
          r.status = fcr_pkg::ST_TOO_LONG;
          r.action = fcr_pkg::ACT_NONE;
          pending_results.push_back(r);
          m_phase = RX_HUNT;
        end else begin
          m_phase = (m_len == 16'd0) ? RX_CRC : RX_PAYLOAD;
        end
      end
      RX_PAYLOAD: begin
        idx = m_count;
        m_crc = crc32_update(m_crc, b);
        m_count = idx + 1;
        if (idx + 1 >= m_len) begin
          m_phase = RX_CRC;
          m_count = 0;
        end
        if (idx < 4) begin
          // Address bytes, big-endian. A write checks its range on the last one.
          m_addr = {m_addr[23:0], b};
          if (idx == 3 && m_cmd == fcr_pkg::OP_WRITE && m_len >= 16'd5)
            m_range_ok = region_fits(m_addr, {16'd0, m_len} - 32'd4);
        end else if (m_cmd == fcr_pkg::OP_VERIFY) begin
          if (idx < 8) m_vlen = {m_vlen[23:0], b};
        end else if (m_cmd == fcr_pkg::OP_WRITE && m_range_ok) begin
          // Pack data little-endian; flush on a full word or the last data byte.
          d = idx - 4;
          lane = d[1:0];
          m_wbuf[lane*8 +: 8] = b;
          if (lane == 2'd3 || d + 32'd1 >= {16'd0, m_len} - 32'd4) begin
            r = '0;
            r.kind = fcr_pkg::KIND_WORD;
            r.status = fcr_pkg::ST_ACK;
            r.action = fcr_pkg::ACT_NONE;
            r.address = m_addr + {d[31:2], 2'b00};
            r.word = m_wbuf;
            r.length = 32'(lane) + 32'd1;
            pending_results.push_back(r);
            m_wbuf = fcr_pkg::WORD_FILL;
          end
        end
      end
      RX_CRC: begin
        m_rx_crc = {m_rx_crc[23:0], b};
        m_count++;
        if (m_count >= 4) begin
          m_phase = RX_HUNT;
          m_count = 0;
          pending_results.push_back(frame_verdict());
        end
      end
      default: m_phase = RX_HUNT;
    endcase
  endtask

  // Offer one byte after a random gap and hold it until the block takes it.
  task automatic send_rx_byte(input logic [7:0] b);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    track_rx_byte(b);
    bytes_sent++;
  endtask

  // Build a frame and send it, or its first keep bytes when keep is not negative.
  // The payload starts with the address, then the verify length for VERIFY.
  task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len,
                            input logic [31:0] addr, input logic [31:0] vlen,
                            input bit corrupt, input int keep);
    logic [7:0]  fb[$];
    logic [7:0]  pb;
    logic [31:0] crc;
    int unsigned n;
    fb = {fcr_pkg::SYNC_BYTE, cmd, len[15:8], len[7:0]};
    if (len <= MAX_LEN) begin
      for (int i = 0; i < len; i++) begin
        if (i < 4) pb = addr[31 - 8*i -: 8];
        else if (i < 8 && cmd == fcr_pkg::OP_VERIFY) pb = vlen[31 - 8*(i-4) -: 8];
        else pb = 8'($urandom_range(0, 255));
        fb.push_back(pb);
      end
      crc = fcr_pkg::CRC_INIT;
      for (int i = 1; i < fb.size(); i++) crc = crc32_update(crc, fb[i]);
      crc = ~crc;
      if (corrupt) crc[$urandom_range(0, 31)] ^= 1'b1;
      fb.push_back(crc[31:24]);
      fb.push_back(crc[23:16]);
      fb.push_back(crc[15:8]);
      fb.push_back(crc[7:0]);
    end
    n = (keep < 0 || keep > fb.size()) ? fb.size() : keep;
    for (int i = 0; i < n; i++) send_rx_byte(fb[i]);
    frames_sent++;
  endtask

  // Drop valid, wait for every expected result, then let the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_region(input logic [fcr_pkg::CFG_IDX_W-1:0] idx,
                              input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == fcr_pkg::REG_REGION_START) m_region_start = value;
    else m_region_end = value;
  endtask

  task automatic set_regions(input logic [31:0] lo_addr, input logic [31:0] hi_addr);
    wait_idle();
    write_region(fcr_pkg::REG_REGION_START, lo_addr);
    write_region(fcr_pkg::REG_REGION_END, hi_addr);
    region_settings++;
  endtask

  // Report one field; returns 1 on a mismatch.
  function automatic bit field_differs(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    if (want === got) return 1'b0;
    $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
    return 1'b1;
  endfunction

  // Compare one accepted result with the oldest expectation.
  task automatic check_result();
    fcr_pkg::result_t want;
    bit               bad;
    if (pending_results.size() == 0) begin
      $display("%0t: expected no result, got kind %0d status %0d action %0d address %h word %h",
               $time, out_kind, out_status, out_action, out_address, out_word);
      errors++;
    end else begin
      want = pending_results.pop_front();
      bad = field_differs("kind", 32'(want.kind), 32'(out_kind));
      bad |= field_differs("status", 32'(want.status), 32'(out_status));
      bad |= field_differs("action", 32'(want.action), 32'(out_action));
      bad |= field_differs("address", want.address, out_address);
      bad |= field_differs("word", want.word, out_word);
      bad |= field_differs("length", want.length, out_length);
      if (bad) errors++;
      if (want.kind == fcr_pkg::KIND_WORD) words_checked++;
      else begin
        verdicts_checked++;
        status_seen[want.status]++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (out_valid && out_ready) check_result();
  end

  // Result side: a random stall before each result, plus an occasional long hold.
  initial begin : result_sink
    int unsigned pause;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      pause = no_idle ? 0 : $urandom_range(0, 14);
      if (sink_hold_cycles != 0) begin
        pause += sink_hold_cycles;
        sink_hold_cycles = 0;
      end
      if (pause != 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Line noise, the simple commands, an empty payload, unknown codes and a bad CRC.
  task automatic test_simple_commands();
    send_rx_byte(8'h00);
    send_rx_byte(8'hFF);
    send_rx_byte(8'h7E);
    send_frame(fcr_pkg::OP_PING, 16'd0, '0, '0, 1'b0, -1);
    send_frame(fcr_pkg::OP_ERASE, 16'd0, '0, '0, 1'b0, -1);
    send_frame(fcr_pkg::OP_JUMP, 16'd1, 32'hA5000000, '0, 1'b0, -1);
    send_frame(8'h00, 16'd0, '0, '0, 1'b0, -1);
    send_frame(8'hFF, 16'd2, 32'h5A5A0000, '0, 1'b0, -1);
    send_frame(fcr_pkg::OP_PING, 16'd0, '0, '0, 1'b1, -1);
  endtask

  // Lengths above the limit are rejected right after the length bytes.
  task automatic test_length_limit();
    send_frame(fcr_pkg::OP_PING, 16'hFFFF, '0, '0, 1'b0, -1);
    send_frame(fcr_pkg::OP_WRITE, 16'(MAX_LEN + 1), '0, '0, 1'b0, -1);
  endtask

  task automatic test_write_frames();
    send_frame(fcr_pkg::OP_WRITE, 16'd0, '0, '0, 1'b0, -1);
    send_frame(fcr_pkg::OP_WRITE, 16'd4, m_region_start, '0, 1'b0, -1);
    send_frame(fcr_pkg::OP_WRITE, 16'd5, m_region_start, '0, 1'b0, -1);
    send_frame(fcr_pkg::OP_WRITE, 16'd11, m_region_start + 32'h100, '0, 1'b0, -1);
    // One byte past the region end: no words are issued.
    send_frame(fcr_pkg::OP_WRITE, 16'd8, m_region_end - 32'd3, '0, 1'b0, -1);
    // Words still stream out of a frame whose CRC turns out bad.
    send_frame(fcr_pkg::OP_WRITE, 16'd12, m_region_start + 32'h40, '0, 1'b1, -1);
  endtask

  task automatic test_verify_frames();
    send_frame(fcr_pkg::OP_VERIFY, 16'd8, m_region_start, 32'h100, 1'b0, -1);
    send_frame(fcr_pkg::OP_VERIFY, 16'd7, m_region_start, 32'h100, 1'b0, -1);
    send_frame(fcr_pkg::OP_VERIFY, 16'd9, m_region_start, 32'h100, 1'b0, -1);
    send_frame(fcr_pkg::OP_VERIFY, 16'd8, m_region_end - 32'h10, 32'h11, 1'b0, -1);
  endtask

  // Region registers at their extremes, including sums that only fit in 33 bits.
  task automatic test_region_extremes();
    set_regions(32'h0, 32'hFFFFFFFF);
    send_frame(fcr_pkg::OP_VERIFY, 16'd8, 32'hFFFFFFF0, 32'h20, 1'b0, -1);
    send_frame(fcr_pkg::OP_VERIFY, 16'd8, 32'h0, 32'hFFFFFFFF, 1'b0, -1);
    send_frame(fcr_pkg::OP_WRITE, 16'd8, 32'hFFFFFFFC, '0, 1'b0, -1);
    send_frame(fcr_pkg::OP_WRITE, 16'd9, 32'hFFFFFFFB, '0, 1'b0, -1);
    set_regions(32'hFFFFFFFF, 32'hFFFFFFFF);
    send_frame(fcr_pkg::OP_VERIFY, 16'd8, 32'hFFFFFFFF, 32'h0, 1'b0, -1);
    send_frame(fcr_pkg::OP_WRITE, 16'd5, 32'hFFFFFFFF, '0, 1'b0, -1);
    set_regions(32'h0, 32'h0);
    send_frame(fcr_pkg::OP_VERIFY, 16'd8, 32'h0, 32'h0, 1'b0, -1);
    send_frame(fcr_pkg::OP_WRITE, 16'd5, 32'h0, '0, 1'b0, -1);
    set_regions(fcr_pkg::REGION_START_RST, fcr_pkg::REGION_END_RST);
  endtask

  // A long write while the result side holds off, so the block stalls its input.
  task automatic test_backpressure();
    wait_idle();
    no_idle = 1'b1;
    sink_hold_cycles = LONG_HOLD;
    send_frame(fcr_pkg::OP_WRITE, 16'd200, m_region_start + 32'h1000, '0, 1'b0, -1);
    wait_idle();
    no_idle = 1'b0;
  endtask

  // Start address near the region edges, inside it, or anywhere.
  function automatic logic [31:0] pick_address(input logic [31:0] count);
    case ($urandom_range(0, 5))
      0, 1, 2: return m_region_start + ($urandom_range(0, 32'h3FF) << 2);
      3:       return m_region_end - count;
      4:       return ($urandom_range(0, 1) != 0) ? m_region_end - count + 32'd1
                                                  : m_region_start - 32'd1;
      default: return $urandom();
    endcase
  endfunction

  task automatic pick_regions();
    logic [31:0] base;
    base = $urandom();
    case ($urandom_range(0, 4))
      0: set_regions(fcr_pkg::REGION_START_RST, fcr_pkg::REGION_END_RST);
      1: set_regions(32'h0, 32'hFFFFFFFF);
      2: set_regions(base, base + $urandom_range(0, 32'h0010_0000));
      3: set_regions(base, $urandom());
      default: set_regions(base, base);
    endcase
  endtask

  // One random frame, a burst of noise, or a broken frame.
  task automatic send_random_frame();
    int unsigned pick;
    int          keep;
    bit          corrupt;
    logic [7:0]  cmd;
    logic [15:0] len;
    logic [31:0] addr;
    logic [31:0] vlen;
    logic [31:0] count;
    pick = $urandom_range(0, 99);
    corrupt = ($urandom_range(0, 9) == 0);
    keep = ($urandom_range(0, 29) == 0) ? int'($urandom_range(1, 8)) : -1;
    addr = $urandom();
    vlen = $urandom();
    if (pick < 8) begin
      repeat ($urandom_range(1, 4)) begin
        do cmd = 8'($urandom_range(0, 255)); while (cmd == fcr_pkg::SYNC_BYTE);
        send_rx_byte(cmd);
      end
    end else if (pick < 32) begin
      if (pick < 18) begin
        case ($urandom_range(0, 2))
          0: cmd = fcr_pkg::OP_PING;
          1: cmd = fcr_pkg::OP_ERASE;
          default: cmd = fcr_pkg::OP_JUMP;
        endcase
      end else if (pick < 26) begin
        do cmd = 8'($urandom_range(0, 255));
        while (cmd >= fcr_pkg::OP_PING && cmd <= fcr_pkg::OP_JUMP);
      end else begin
        cmd = 8'($urandom_range(0, 255));
      end
      if (pick < 26) len = 16'($urandom_range(0, 6));
      else if ($urandom_range(0, 3) == 0) len = 16'(MAX_LEN + 1);
      else len = 16'($urandom_range(MAX_LEN + 1, 16'hFFFF));
      send_frame(cmd, len, addr, vlen, corrupt, keep);
    end else if (pick < 70) begin
      case ($urandom_range(0, 9))
        0:       len = 16'($urandom_range(0, 4));
        1:       len = 16'($urandom_range(41, 200));
        default: len = 16'($urandom_range(5, 40));
      endcase
      count = (len >= 16'd5) ? {16'd0, len} - 32'd4 : 32'd0;
      send_frame(fcr_pkg::OP_WRITE, len, pick_address(count), vlen, corrupt, keep);
    end else begin
      len = ($urandom_range(0, 6) == 0) ? 16'($urandom_range(0, 12)) : 16'd8;
      addr = pick_address($urandom_range(0, 32'h400));
      case ($urandom_range(0, 3))
        0: vlen = $urandom_range(0, 32'h400);
        1: vlen = m_region_end - addr;
        2: vlen = m_region_end - addr + 32'd1;
        default: vlen = $urandom();
      endcase
      send_frame(fcr_pkg::OP_VERIFY, len, addr, vlen, corrupt, keep);
    end
  endtask

  // Random traffic with region changes between frames and idle-free stretches.
  task automatic test_random_traffic();
    int unsigned first_byte;
    int unsigned frame_no;
    first_byte = bytes_sent;
    frame_no = 0;
    while (bytes_sent - first_byte < RANDOM_BYTES) begin
      if (frame_no % 16 == 15) pick_regions();
      if ($urandom_range(0, 7) == 0) no_idle = ($urandom_range(0, 2) == 0);
      send_random_frame();
      frame_no++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_simple_commands();
    test_length_limit();
    test_write_frames();
    test_verify_frames();
    test_region_extremes();
    test_backpressure();
    test_random_traffic();
    wait_idle();

    $display("Sent %0d bytes in %0d frames under %0d region settings; checked %0d words.",
             bytes_sent, frames_sent, region_settings, words_checked);
    $display("Verdicts %0d: ack %0d, long %0d, crc %0d, short %0d, range %0d, vlen %0d, unk %0d.",
             verdicts_checked, status_seen[fcr_pkg::ST_ACK], status_seen[fcr_pkg::ST_TOO_LONG],
             status_seen[fcr_pkg::ST_CRC_BAD], status_seen[fcr_pkg::ST_WR_SHORT],
             status_seen[fcr_pkg::ST_RANGE], status_seen[fcr_pkg::ST_VLEN_BAD],
             status_seen[fcr_pkg::ST_UNKNOWN]);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
